// ----- src/rpsu_pkg.sv -----
// ============================================================================
// rpsu_pkg: shared types and codes for the privileged system unit
// Holds the transaction structs, instruction, privilege, exception and TLB
// flush codes, mstatus bit positions and the ASID mask.
// ============================================================================
`default_nettype none

package rpsu_pkg;

    // Number of ASID bits that the address translation supports.
    localparam int ASID_WIDTH = 9;
    localparam int ASID_OUT_BITS = 9;
    localparam int ASID_KEEP = (ASID_WIDTH > ASID_OUT_BITS) ? ASID_OUT_BITS : ASID_WIDTH;
    localparam logic [ASID_OUT_BITS-1:0] ASID_MASK =
        ASID_OUT_BITS'((33'd1 << ASID_KEEP) - 33'd1);

    // Instruction codes.
    localparam logic [2:0] OP_ECALL  = 3'd0;
    localparam logic [2:0] OP_SRET   = 3'd1;
    localparam logic [2:0] OP_MRET   = 3'd2;
    localparam logic [2:0] OP_WFI    = 3'd3;
    localparam logic [2:0] OP_SFENCE = 3'd4;

    // Privilege levels.
    localparam logic [1:0] PRIV_U    = 2'd0;
    localparam logic [1:0] PRIV_S    = 2'd1;
    localparam logic [1:0] PRIV_RSVD = 2'd2;
    localparam logic [1:0] PRIV_M    = 2'd3;

    // Exception codes.
    localparam logic [2:0] EXC_NONE    = 3'd0;
    localparam logic [2:0] EXC_ILLEGAL = 3'd1;
    localparam logic [2:0] EXC_ECALL_U = 3'd2;
    localparam logic [2:0] EXC_ECALL_S = 3'd3;
    localparam logic [2:0] EXC_ECALL_M = 3'd4;

    // TLB flush kinds.
    localparam logic [2:0] FLUSH_NONE      = 3'd0;
    localparam logic [2:0] FLUSH_ALL       = 3'd1;
    localparam logic [2:0] FLUSH_ASID      = 3'd2;
    localparam logic [2:0] FLUSH_ADDR      = 3'd3;
    localparam logic [2:0] FLUSH_ASID_ADDR = 3'd4;

    // mstatus bit positions.
    localparam int ST_SIE  = 1;
    localparam int ST_MIE  = 3;
    localparam int ST_SPIE = 5;
    localparam int ST_MPIE = 7;
    localparam int ST_SPP  = 8;
    localparam int ST_MPP_LO = 11;
    localparam int ST_MPP_HI = 12;
    localparam int ST_MPRV = 17;
    localparam int ST_TVM  = 20;
    localparam int ST_TW   = 21;
    localparam int ST_TSR  = 22;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [1:0]  cur_priv;
        logic [31:0] status_in;
        logic [31:0] sepc_in;
        logic [31:0] mepc_in;
        logic [4:0]  rs1_index;
        logic [4:0]  rs2_index;
        logic [31:0] rs1_value;
        logic [31:0] rs2_value;
    } in_item_t;

    typedef struct packed {
        logic [2:0]               exception;
        logic [1:0]               new_priv;
        logic [31:0]              status_out;
        logic                     redirect;
        logic [31:0]              next_pc;
        logic                     standby;
        logic [2:0]               flush_kind;
        logic [ASID_OUT_BITS-1:0] flush_asid;
        logic [31:0]              flush_addr;
    } out_item_t;

endpackage

`default_nettype wire

// ----- src/rpsu_exec.sv -----
// ============================================================================
// rpsu_exec: decode and execute one privileged system instruction
// Checks privilege and the TSR, TW and TVM trap bits, then builds the new
// privilege, mstatus, return target, standby request and TLB flush command.
// ============================================================================
`default_nettype none

module rpsu_exec (
    input  rpsu_pkg::in_item_t  item_i,
    output rpsu_pkg::out_item_t result_o
);

    logic [2:0]  exc;
    logic [1:0]  npriv;
    logic [31:0] nst;
    logic        redir;
    logic [31:0] npc;
    logic        stby;
    logic [2:0]  kind;
    logic [rpsu_pkg::ASID_OUT_BITS-1:0] asid;
    logic [31:0] addr;
    logic        in_u;
    logic        in_s;
    logic        rs1_zero;
    logic        rs2_zero;
    logic [1:0]  mpp;

    always_comb begin
        in_u     = (item_i.cur_priv == rpsu_pkg::PRIV_U);
        in_s     = (item_i.cur_priv == rpsu_pkg::PRIV_S);
        rs1_zero = (item_i.rs1_index == 5'd0);
        rs2_zero = (item_i.rs2_index == 5'd0);
        mpp      = item_i.status_in[rpsu_pkg::ST_MPP_HI:rpsu_pkg::ST_MPP_LO];

        exc   = rpsu_pkg::EXC_NONE;
        npriv = item_i.cur_priv;
        nst   = item_i.status_in;
        redir = 1'b0;
        npc   = 32'd0;
        stby  = 1'b0;
        kind  = rpsu_pkg::FLUSH_NONE;
        asid  = '0;
        addr  = 32'd0;

        if (item_i.cur_priv == rpsu_pkg::PRIV_RSVD) begin
            exc = rpsu_pkg::EXC_ILLEGAL;
        end else begin
            case (item_i.opcode)
                rpsu_pkg::OP_ECALL: begin
                    if (in_u) begin
                        exc = rpsu_pkg::EXC_ECALL_U;
                    end else if (in_s) begin
                        exc = rpsu_pkg::EXC_ECALL_S;
                    end else begin
                        exc = rpsu_pkg::EXC_ECALL_M;
                    end
                end
                rpsu_pkg::OP_SRET: begin
                    if (in_u || (in_s && item_i.status_in[rpsu_pkg::ST_TSR])) begin
                        exc = rpsu_pkg::EXC_ILLEGAL;
                    end else begin
                        npriv = item_i.status_in[rpsu_pkg::ST_SPP]
                              ? rpsu_pkg::PRIV_S : rpsu_pkg::PRIV_U;
                        nst[rpsu_pkg::ST_SIE]  = item_i.status_in[rpsu_pkg::ST_SPIE];
                        nst[rpsu_pkg::ST_SPIE] = 1'b1;
                        nst[rpsu_pkg::ST_SPP]  = 1'b0;
                        nst[rpsu_pkg::ST_MPRV] = 1'b0;
                        redir = 1'b1;
                        npc   = item_i.sepc_in;
                    end
                end
                rpsu_pkg::OP_MRET: begin
                    if (item_i.cur_priv != rpsu_pkg::PRIV_M) begin
                        exc = rpsu_pkg::EXC_ILLEGAL;
                    end else begin
                        // A reserved MPP value is passed through unchanged.
                        npriv = mpp;
                        nst[rpsu_pkg::ST_MIE]  = item_i.status_in[rpsu_pkg::ST_MPIE];
                        nst[rpsu_pkg::ST_MPIE] = 1'b1;
                        nst[rpsu_pkg::ST_MPP_HI:rpsu_pkg::ST_MPP_LO] = rpsu_pkg::PRIV_U;
                        if (mpp != rpsu_pkg::PRIV_M) begin
                            nst[rpsu_pkg::ST_MPRV] = 1'b0;
                        end
                        redir = 1'b1;
                        npc   = item_i.mepc_in;
                    end
                end
                rpsu_pkg::OP_WFI: begin
                    if (in_u || (in_s && item_i.status_in[rpsu_pkg::ST_TW])) begin
                        exc = rpsu_pkg::EXC_ILLEGAL;
                    end else begin
                        stby = 1'b1;
                    end
                end
                rpsu_pkg::OP_SFENCE: begin
                    if (in_u || (in_s && item_i.status_in[rpsu_pkg::ST_TVM])) begin
                        exc = rpsu_pkg::EXC_ILLEGAL;
                    end else begin
                        if (!rs2_zero) begin
                            asid = item_i.rs2_value[rpsu_pkg::ASID_OUT_BITS-1:0]
                                 & rpsu_pkg::ASID_MASK;
                        end
                        if (!rs1_zero) begin
                            addr = item_i.rs1_value;
                        end
                        if (rs1_zero && rs2_zero) begin
                            kind = rpsu_pkg::FLUSH_ALL;
                        end else if (rs1_zero) begin
                            kind = rpsu_pkg::FLUSH_ASID;
                        end else if (rs2_zero) begin
                            kind = rpsu_pkg::FLUSH_ADDR;
                        end else begin
                            kind = rpsu_pkg::FLUSH_ASID_ADDR;
                        end
                    end
                end
                default: begin
                    exc = rpsu_pkg::EXC_ILLEGAL;
                end
            endcase
        end

        result_o.exception  = exc;
        result_o.new_priv   = npriv;
        result_o.status_out = nst;
        result_o.redirect   = redir;
        result_o.next_pc    = npc;
        result_o.standby    = stby;
        result_o.flush_kind = kind;
        result_o.flush_asid = asid;
        result_o.flush_addr = addr;
    end

endmodule

`default_nettype wire

// ----- src/riscv_privileged_system_unit.sv -----
// An accepted instruction is captured in the input register, then moves to the
// result register, which drives m_valid and m_data.
// Throughput: one instruction per cycle; the input register and the result
// register each advance whenever the stage after them is empty or draining.
// Reset clears only the two stage valid bits; the data registers are not reset.
// ============================================================================
// riscv_privileged_system_unit: RV32 privileged system instruction unit
// Executes ECALL, SRET, MRET, WFI and SFENCE.VMA between an input register
// and a result register, with valid/ready flow control on both sides.
// ============================================================================
`default_nettype none

module riscv_privileged_system_unit (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  rpsu_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  wire                  m_ready,
    output rpsu_pkg::out_item_t  m_data
);

    rpsu_pkg::in_item_t  in_reg;
    logic                in_valid_reg;
    logic                in_valid_next;
    rpsu_pkg::out_item_t out_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    rpsu_pkg::out_item_t exec_result;
    logic                out_ready;
    logic                in_ready;

    rpsu_exec u_exec (
        .item_i   (in_reg),
        .result_o (exec_result)
    );

    assign out_ready = !out_valid_reg || m_ready;
    assign in_ready  = !in_valid_reg || out_ready;
    assign s_ready   = in_ready;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    always_comb begin
        in_valid_next  = in_ready ? s_valid : in_valid_reg;
        out_valid_next = out_ready ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && s_valid) begin
            in_reg <= s_data;
        end
        if (out_ready && in_valid_reg) begin
            out_reg <= exec_result;
        end
    end

    // An accepted transaction always lands in the input register.
    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> in_valid_reg)
        else $error("accepted transaction not captured");

    // A stalled input stage keeps its instruction.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_ready) |=> (in_valid_reg && $stable(in_reg)))
        else $error("input stage lost its instruction during a stall");

    // A trapped instruction has no side effects.
    a_trap_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.exception != rpsu_pkg::EXC_NONE)) |->
        (!m_data.redirect && !m_data.standby
         && (m_data.flush_kind == rpsu_pkg::FLUSH_NONE)))
        else $error("trapped instruction reports a side effect");

    // A result moves to the output whenever the output is free.
    a_out_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_ready) |=> out_valid_reg)
        else $error("result not moved into the output register");

endmodule

`default_nettype wire
